@@ hdl/erra_pkg.sv @@
// Shared types, constants and the CORDIC arctangent table of the remap address block.
`default_nettype none
package erra_pkg;

	localparam int MAX_WIDTH  = 8192;
	localparam int MAX_HEIGHT = 4096;
	localparam int FRAC_BITS  = 16;

	localparam int COL_W        = $clog2(MAX_WIDTH);
	localparam int ROW_W        = $clog2(MAX_HEIGHT);
	localparam int ENTRY_W      = FRAC_BITS + 2;
	localparam int ROW_BITS     = 3 * ENTRY_W;
	localparam int WIDTH_REG_W  = 14;
	localparam int HEIGHT_REG_W = 13;
	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = ROW_BITS;

	localparam int ANG_W        = 23;
	localparam int NUM_ITER     = 19;
	localparam int HALF_TURN    = 524288;
	localparam int QUARTER_TURN = 262144;
	localparam int INV_GAIN_Q30 = 652032874;
	localparam int INV_GAIN_Q24 = 10188014;

	localparam logic [CFG_IDX_W-1:0] REG_ROW0   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ROW1   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ROW2   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd4;

	localparam logic [ROW_BITS-1:0] ROW0_RST = ROW_BITS'(1) << FRAC_BITS;
	localparam logic [ROW_BITS-1:0] ROW1_RST = ROW_BITS'(1) << (FRAC_BITS + ENTRY_W);
	localparam logic [ROW_BITS-1:0] ROW2_RST = ROW_BITS'(1) << (FRAC_BITS + 2 * ENTRY_W);
	localparam logic [WIDTH_REG_W-1:0]  WIDTH_RST  = 14'd4096;
	localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RST = 13'd2048;

	typedef struct packed {
		logic [COL_W-1:0] dest_col;
		logic [ROW_W-1:0] dest_row;
	} dest_t;

	typedef struct packed {
		logic [COL_W-1:0] src_col;
		logic [ROW_W-1:0] src_row;
	} src_t;

	// atan(2^-i) in units of pi/2^19
	function automatic logic signed [ANG_W-1:0] atan_step(input int i);
		logic signed [ANG_W-1:0] r;
		case (i)
			0:  r = 23'sd131072;
			1:  r = 23'sd77376;
			2:  r = 23'sd40884;
			3:  r = 23'sd20753;
			4:  r = 23'sd10417;
			5:  r = 23'sd5213;
			6:  r = 23'sd2607;
			7:  r = 23'sd1304;
			8:  r = 23'sd652;
			9:  r = 23'sd326;
			10: r = 23'sd163;
			11: r = 23'sd81;
			12: r = 23'sd41;
			13: r = 23'sd20;
			14: r = 23'sd10;
			15: r = 23'sd5;
			16: r = 23'sd3;
			17: r = 23'sd1;
			18: r = 23'sd1;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

@@ hdl/equirect_rotation_remap_address.sv @@
// Top level: pipelined equirectangular rotation remap address generator.
`default_nettype none
// For each destination pixel the block returns the source pixel of the rotated panorama.
// One pixel is taken in every clock: busy stays low and cfg_ready stays high. The result
// strobe done rises for each taken pixel after the forward map's two restoring dividers
// (21 bit steps each), the three 19-step CORDIC chains (sin/cos, then two arctangents)
// and the multiply stages between them. The receiver cannot stall; results come out in
// input order. Configuration writes are to be made only while no pixel is in flight;
// the user is bound to this, and the block itself does not enforce it.
module equirect_rotation_remap_address (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	output logic                                 busy,
	input  wire erra_pkg::dest_t                 dest,
	output logic                                 done,
	output erra_pkg::src_t                       src,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [erra_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [erra_pkg::CFG_DATA_W-1:0] cfg_data
);
	import erra_pkg::*;

	localparam int DIV_W  = 34;
	localparam int Q_W    = 21;
	localparam int SC_W   = 33;
	localparam int DIR_W  = 34;
	localparam int MP_W   = ENTRY_W + DIR_W;
	localparam int ACC_W  = MP_W + 2;
	localparam int VW     = 37;
	localparam int GAIN_W = 25;
	localparam int RP_W   = VW + GAIN_W;
	localparam int NUM_W  = 22;
	localparam int PX_W   = NUM_W + COL_W;
	localparam int PIPE_DEPTH = 1 + Q_W + (NUM_ITER + 1) + 4 + (NUM_ITER + 1) + 1
		+ (NUM_ITER + 1) + 3;

	localparam logic signed [ANG_W-1:0]  HALF_A    = ANG_W'(HALF_TURN);
	localparam logic signed [ANG_W-1:0]  QUARTER_A = ANG_W'(QUARTER_TURN);
	localparam logic signed [SC_W-1:0]   SC_X0     = SC_W'(INV_GAIN_Q30);
	localparam logic signed [GAIN_W-1:0] MAG_GAIN  = GAIN_W'(INV_GAIN_Q24);

	typedef struct packed {
		logic [DIV_W-1:0] rem_lon;
		logic [DIV_W-1:0] rem_lat;
		logic [Q_W-1:0]   q_lon;
		logic [Q_W-1:0]   q_lat;
	} div_t;

	typedef struct packed {
		logic signed [ANG_W-1:0] a;
		logic signed [SC_W-1:0]  x;
		logic signed [SC_W-1:0]  y;
		logic                    flip;
	} sc_t;

	typedef struct packed {
		logic signed [ANG_W-1:0] a;
		logic signed [VW-1:0]    x;
		logic signed [VW-1:0]    y;
	} vc_t;

	function automatic sc_t sc_begin(input logic signed [ANG_W-1:0] a_in);
		sc_t r;
		r.x    = SC_X0;
		r.y    = '0;
		r.flip = 1'b0;
		r.a    = a_in;
		if (a_in > QUARTER_A) begin
			r.a    = a_in - HALF_A;
			r.flip = 1'b1;
		end else if (a_in < -QUARTER_A) begin
			r.a    = a_in + HALF_A;
			r.flip = 1'b1;
		end
		return r;
	endfunction

	function automatic sc_t sc_iter(input sc_t c, input int i);
		sc_t r;
		logic signed [SC_W-1:0]  x, y, dx, dy;
		logic signed [ANG_W-1:0] a;
		x  = c.x;
		y  = c.y;
		a  = c.a;
		dx = y >>> i;
		dy = x >>> i;
		r.flip = c.flip;
		if (!a[ANG_W-1]) begin
			r.x = x - dx;
			r.y = y + dy;
			r.a = a - atan_step(i);
		end else begin
			r.x = x + dx;
			r.y = y - dy;
			r.a = a + atan_step(i);
		end
		return r;
	endfunction

	function automatic vc_t vc_begin(input logic signed [VW-1:0] x, input logic signed [VW-1:0] y);
		vc_t r;
		r.a = '0;
		r.x = x;
		r.y = y;
		if (x < 0) begin
			r.a = (y >= 0) ? HALF_A : -HALF_A;
			r.x = -x;
			r.y = -y;
		end
		return r;
	endfunction

	function automatic vc_t vc_iter(input vc_t c, input int i);
		vc_t r;
		logic signed [VW-1:0]    x, y, dx, dy;
		logic signed [ANG_W-1:0] a;
		x  = c.x;
		y  = c.y;
		a  = c.a;
		dx = y >>> i;
		dy = x >>> i;
		if (y > 0) begin
			r.x = x + dx;
			r.y = y - dy;
			r.a = a + atan_step(i);
		end else begin
			r.x = x - dx;
			r.y = y + dy;
			r.a = a - atan_step(i);
		end
		return r;
	endfunction

	// configuration registers
	logic [ROW_BITS-1:0]     row_q [3];
	logic [WIDTH_REG_W-1:0]  width_q;
	logic [HEIGHT_REG_W-1:0] height_q;

	assign cfg_ready = 1'b1;
	assign busy      = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q[0] <= ROW0_RST;
			row_q[1] <= ROW1_RST;
			row_q[2] <= ROW2_RST;
			width_q  <= WIDTH_RST;
			height_q <= HEIGHT_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_ROW0:   row_q[0] <= cfg_data;
				REG_ROW1:   row_q[1] <= cfg_data;
				REG_ROW2:   row_q[2] <= cfg_data;
				REG_WIDTH:  width_q  <= cfg_data[WIDTH_REG_W-1:0];
				REG_HEIGHT: height_q <= cfg_data[HEIGHT_REG_W-1:0];
				default: ;
			endcase
		end
	end

	// spans W-1 and H-1 after clamping the dimensions
	logic [WIDTH_REG_W-1:0]  wclamp;
	logic [HEIGHT_REG_W-1:0] hclamp;
	logic [COL_W-1:0]        wspan;
	logic [ROW_W-1:0]        hspan;

	always_comb begin
		if (width_q < WIDTH_REG_W'(2))
			wclamp = WIDTH_REG_W'(2);
		else if (width_q > WIDTH_REG_W'(MAX_WIDTH))
			wclamp = WIDTH_REG_W'(MAX_WIDTH);
		else
			wclamp = width_q;
		if (height_q < HEIGHT_REG_W'(2))
			hclamp = HEIGHT_REG_W'(2);
		else if (height_q > HEIGHT_REG_W'(MAX_HEIGHT))
			hclamp = HEIGHT_REG_W'(MAX_HEIGHT);
		else
			hclamp = height_q;
		wspan = COL_W'(wclamp - WIDTH_REG_W'(1));
		hspan = ROW_W'(hclamp - HEIGHT_REG_W'(1));
	end

	logic accept;
	assign accept = start && !busy;

	logic [PIPE_DEPTH:1] vld_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s <= '0;
		else
			vld_s <= {vld_s[PIPE_DEPTH-1:1], accept};
	end

	// entry: clamp pixel, rounded numerators of the forward map
	logic [COL_W-1:0] u_c;
	logic [ROW_W-1:0] v_c;
	div_t             div_s [0:Q_W];

	assign u_c = (dest.dest_col > wspan) ? wspan : dest.dest_col;
	assign v_c = (dest.dest_row > hspan) ? hspan : dest.dest_row;

	always_ff @(posedge clk) begin
		div_s[0].rem_lon <= DIV_W'({u_c, 20'b0}) + DIV_W'(wspan >> 1);
		div_s[0].rem_lat <= DIV_W'({v_c, 19'b0}) + DIV_W'(hspan >> 1);
		div_s[0].q_lon   <= '0;
		div_s[0].q_lat   <= '0;
	end

	// restoring division, one quotient bit per stage, MSB first
	for (genvar gs = 0; gs < Q_W; gs++) begin : g_div
		localparam int K = Q_W - 1 - gs;
		logic [DIV_W:0] dl_lon, dl_lat;
		logic           ge_lon, ge_lat;
		div_t           nxt;
		always_comb begin
			dl_lon = (DIV_W + 1)'(wspan) << K;
			dl_lat = (DIV_W + 1)'(hspan) << K;
			ge_lon = {1'b0, div_s[gs].rem_lon} >= dl_lon;
			ge_lat = {1'b0, div_s[gs].rem_lat} >= dl_lat;
			nxt.rem_lon = ge_lon ? div_s[gs].rem_lon - dl_lon[DIV_W-1:0] : div_s[gs].rem_lon;
			nxt.rem_lat = ge_lat ? div_s[gs].rem_lat - dl_lat[DIV_W-1:0] : div_s[gs].rem_lat;
			nxt.q_lon   = div_s[gs].q_lon | (ge_lon ? (Q_W'(1) << K) : '0);
			nxt.q_lat   = div_s[gs].q_lat | (ge_lat ? (Q_W'(1) << K) : '0);
		end
		always_ff @(posedge clk) begin
			div_s[gs+1] <= nxt;
		end
	end

	// sin/cos of longitude and latitude
	sc_t sc_lon_s [0:NUM_ITER];
	sc_t sc_lat_s [0:NUM_ITER];
	logic signed [ANG_W-1:0] lon0_c, lat0_c;

	assign lon0_c = $signed(ANG_W'(div_s[Q_W].q_lon)) - HALF_A;
	assign lat0_c = QUARTER_A - $signed(ANG_W'(div_s[Q_W].q_lat));

	always_ff @(posedge clk) begin
		sc_lon_s[0] <= sc_begin(lon0_c);
		sc_lat_s[0] <= sc_begin(lat0_c);
	end

	for (genvar gi = 0; gi < NUM_ITER; gi++) begin : g_sc
		always_ff @(posedge clk) begin
			sc_lon_s[gi+1] <= sc_iter(sc_lon_s[gi], gi);
			sc_lat_s[gi+1] <= sc_iter(sc_lat_s[gi], gi);
		end
	end

	logic signed [SC_W-1:0] ct_s1, st_s1, cp_s1, sp_s1;
	logic signed [SC_W-1:0] xl_c, yl_c, xp_c, yp_c;

	always_comb begin
		xl_c = sc_lon_s[NUM_ITER].x;
		yl_c = sc_lon_s[NUM_ITER].y;
		xp_c = sc_lat_s[NUM_ITER].x;
		yp_c = sc_lat_s[NUM_ITER].y;
	end

	always_ff @(posedge clk) begin
		ct_s1 <= sc_lon_s[NUM_ITER].flip ? -xl_c : xl_c;
		st_s1 <= sc_lon_s[NUM_ITER].flip ? -yl_c : yl_c;
		cp_s1 <= sc_lat_s[NUM_ITER].flip ? -xp_c : xp_c;
		sp_s1 <= sc_lat_s[NUM_ITER].flip ? -yp_c : yp_c;
	end

	// unit direction
	logic signed [2*SC_W-1:0] p0_s2, p1_s2;
	logic signed [SC_W-1:0]   sp_s2;

	always_ff @(posedge clk) begin
		p0_s2 <= cp_s1 * ct_s1;
		p1_s2 <= cp_s1 * st_s1;
		sp_s2 <= sp_s1;
	end

	// transpose multiply: nine entry products
	logic signed [DIR_W-1:0] dir_c [3];
	logic signed [MP_W-1:0]  mp_s3 [3][3];

	always_comb begin
		dir_c[0] = DIR_W'(p0_s2 >>> 30);
		dir_c[1] = DIR_W'(p1_s2 >>> 30);
		dir_c[2] = DIR_W'(sp_s2);
	end

	for (genvar gr = 0; gr < 3; gr++) begin : g_mrow
		for (genvar gc = 0; gc < 3; gc++) begin : g_mcol
			logic signed [ENTRY_W-1:0] ent;
			logic signed [MP_W-1:0]    prod;
			always_comb begin
				ent  = row_q[gr][gc*ENTRY_W +: ENTRY_W];
				prod = ent * dir_c[gr];
			end
			always_ff @(posedge clk) begin
				mp_s3[gr][gc] <= prod;
			end
		end
	end

	logic signed [VW-1:0] rot_s4 [3];

	for (genvar gj = 0; gj < 3; gj++) begin : g_rot
		logic signed [ACC_W-1:0] acc;
		always_comb begin
			acc = ACC_W'(mp_s3[0][gj]) + ACC_W'(mp_s3[1][gj]) + ACC_W'(mp_s3[2][gj]);
		end
		always_ff @(posedge clk) begin
			rot_s4[gj] <= VW'(acc >>> FRAC_BITS);
		end
	end

	// longitude of the rotated direction
	vc_t                  v1_s [0:NUM_ITER];
	logic signed [VW-1:0] z_s  [0:NUM_ITER];

	always_ff @(posedge clk) begin
		v1_s[0] <= vc_begin(rot_s4[0], rot_s4[1]);
		z_s[0]  <= rot_s4[2];
	end

	for (genvar gi = 0; gi < NUM_ITER; gi++) begin : g_v1
		always_ff @(posedge clk) begin
			v1_s[gi+1] <= vc_iter(v1_s[gi], gi);
			z_s[gi+1]  <= z_s[gi];
		end
	end

	// strip CORDIC gain from the horizontal magnitude
	logic signed [RP_W-1:0]  rp_s5;
	logic signed [VW-1:0]    z_s5;
	logic signed [ANG_W-1:0] lon_s5;
	logic signed [VW-1:0]    mag_c;

	assign mag_c = v1_s[NUM_ITER].x;

	always_ff @(posedge clk) begin
		rp_s5  <= mag_c * MAG_GAIN;
		z_s5   <= z_s[NUM_ITER];
		lon_s5 <= v1_s[NUM_ITER].a;
	end

	// latitude
	vc_t                     v2_s  [0:NUM_ITER];
	logic signed [ANG_W-1:0] lon_s [0:NUM_ITER];

	always_ff @(posedge clk) begin
		v2_s[0]  <= vc_begin(VW'(rp_s5 >>> 24), z_s5);
		lon_s[0] <= lon_s5;
	end

	for (genvar gi = 0; gi < NUM_ITER; gi++) begin : g_v2
		always_ff @(posedge clk) begin
			v2_s[gi+1]  <= vc_iter(v2_s[gi], gi);
			lon_s[gi+1] <= lon_s[gi];
		end
	end

	// inverse map to pixels
	logic signed [ANG_W-1:0] nl_s6, nr_s6;

	always_ff @(posedge clk) begin
		nl_s6 <= lon_s[NUM_ITER] + HALF_A;
		nr_s6 <= QUARTER_A - v2_s[NUM_ITER].a;
	end

	logic            pos_l_s7, pos_r_s7;
	logic [PX_W-1:0] px_l_s7, px_r_s7;

	always_ff @(posedge clk) begin
		pos_l_s7 <= nl_s6 > 0;
		pos_r_s7 <= nr_s6 > 0;
		px_l_s7  <= PX_W'(nl_s6[NUM_W-1:0]) * PX_W'(wspan);
		px_r_s7  <= PX_W'(nr_s6[NUM_W-1:0]) * PX_W'(hspan);
	end

	logic [PX_W-1:0] pc_l_c, pc_r_c;
	src_t            src_q;

	assign pc_l_c = px_l_s7 >> 20;
	assign pc_r_c = px_r_s7 >> 19;

	always_ff @(posedge clk) begin
		if (!pos_l_s7)
			src_q.src_col <= '0;
		else if (pc_l_c > PX_W'(wspan))
			src_q.src_col <= wspan;
		else
			src_q.src_col <= pc_l_c[COL_W-1:0];
		if (!pos_r_s7)
			src_q.src_row <= '0;
		else if (pc_r_c > PX_W'(hspan))
			src_q.src_row <= hspan;
		else
			src_q.src_row <= pc_r_c[ROW_W-1:0];
	end

	assign src  = src_q;
	assign done = vld_s[PIPE_DEPTH];

	a_col_in_image: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> src.src_col <= wspan)
		else $error("source column beyond image width");

	a_row_in_image: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> src.src_row <= hspan)
		else $error("source row beyond image height");

	a_quotient_bound: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[Q_W+1] |-> div_s[Q_W].q_lon <= (Q_W'(1) << (Q_W - 1)))
		else $error("longitude quotient out of range");

endmodule
`default_nettype wire

@@ test/tb_equirect_rotation_remap_address.sv @@
// Testbench for the equirectangular rotation remap address generator.
`timescale 1ns / 100ps
`default_nettype none

class remap_scoreboard;
	erra_pkg::src_t pending[$];
	int mismatches = 0;

	function void note_pixel(erra_pkg::src_t exp_src);
		pending.push_back(exp_src);
	endfunction

	function void check_src(erra_pkg::src_t got);
		erra_pkg::src_t exp_src;
		if (pending.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected result col=%0d row=%0d", got.src_col, got.src_row);
			return;
		end
		exp_src = pending.pop_front();
		if (got.src_col !== exp_src.src_col || got.src_row !== exp_src.src_row) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch: expected col=%0d row=%0d, got col=%0d row=%0d",
					exp_src.src_col, exp_src.src_row, got.src_col, got.src_row);
		end
	endfunction
endclass

module tb_equirect_rotation_remap_address;
	import erra_pkg::*;

	localparam int LATENCY = 90;
	localparam longint CYCLE_LIMIT = 200000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	dest_t dest = '0;
	logic done;
	src_t src;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	logic [ROW_BITS-1:0] mat_row [3];
	logic [WIDTH_REG_W-1:0] width_reg;
	logic [HEIGHT_REG_W-1:0] height_reg;

	remap_scoreboard board = new();
	longint cycles = 0;
	bit calm = 1'b0;

	equirect_rotation_remap_address uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .dest(dest),
		.done(done), .src(src), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (done)
			board.check_src(src);
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_equirect_rotation_remap_address NOT OK");
			$finish;
		end
	end

	function automatic longint fshift(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint matrix_coef(logic [ROW_BITS-1:0] r, int j);
		logic signed [ENTRY_W-1:0] e;
		e = r[j*ENTRY_W +: ENTRY_W];
		return longint'(e);
	endfunction

	function automatic longint arctan_unit(int i);
		longint t[NUM_ITER] = '{131072, 77376, 40884, 20753, 10417, 5213, 2607, 1304,
			652, 326, 163, 81, 41, 20, 10, 5, 3, 1, 1};
		return t[i];
	endfunction

	task automatic rotate_angle(input longint ang, output longint cv, output longint sv);
		bit flip;
		longint x, y, dx, dy;
		flip = 0;
		x = INV_GAIN_Q30;
		y = 0;
		if (ang > QUARTER_TURN) begin
			ang -= HALF_TURN; flip = 1;
		end else if (ang < -QUARTER_TURN) begin
			ang += HALF_TURN; flip = 1;
		end
		for (int i = 0; i < NUM_ITER; i++) begin
			dx = fshift(y, i);
			dy = fshift(x, i);
			if (ang >= 0) begin
				x -= dx; y += dy; ang -= arctan_unit(i);
			end else begin
				x += dx; y -= dy; ang += arctan_unit(i);
			end
		end
		cv = flip ? -x : x;
		sv = flip ? -y : y;
	endtask

	task automatic vector_angle(input longint x, input longint y, output longint ang,
			output longint mag);
		longint dx, dy;
		ang = 0;
		if (x < 0) begin
			ang = (y >= 0) ? HALF_TURN : -HALF_TURN;
			x = -x;
			y = -y;
		end
		for (int i = 0; i < NUM_ITER; i++) begin
			dx = fshift(y, i);
			dy = fshift(x, i);
			if (y > 0) begin
				x += dx; y -= dy; ang += arctan_unit(i);
			end else begin
				x -= dx; y += dy; ang -= arctan_unit(i);
			end
		end
		mag = x;
	endtask

	function automatic longint pixel_of(longint num, longint span, int sh);
		longint p;
		if (num <= 0)
			return 0;
		p = (num * span) >>> sh;
		return p > span ? span : p;
	endfunction

	task automatic source_pixel(input dest_t d, output src_t s);
		longint wspan, hspan, u, v, lon, lat, ct, st, cp, sp, mag, rho, acc;
		longint dir[3], rot[3];
		wspan = width_reg < 2 ? 2 : (width_reg > MAX_WIDTH ? MAX_WIDTH : width_reg);
		hspan = height_reg < 2 ? 2 : (height_reg > MAX_HEIGHT ? MAX_HEIGHT : height_reg);
		wspan -= 1;
		hspan -= 1;
		u = d.dest_col;
		v = d.dest_row;
		if (u > wspan) u = wspan;
		if (v > hspan) v = hspan;
		lon = ((u << 20) + (wspan >> 1)) / wspan - HALF_TURN;
		lat = QUARTER_TURN - ((v << 19) + (hspan >> 1)) / hspan;
		rotate_angle(lon, ct, st);
		rotate_angle(lat, cp, sp);
		dir[0] = fshift(cp * ct, 30);
		dir[1] = fshift(cp * st, 30);
		dir[2] = sp;
		// transpose: column j of the matrix dots the direction
		for (int j = 0; j < 3; j++) begin
			acc = 0;
			for (int i = 0; i < 3; i++)
				acc += matrix_coef(mat_row[i], j) * dir[i];
			rot[j] = fshift(acc, FRAC_BITS);
		end
		vector_angle(rot[0], rot[1], lon, mag);
		rho = fshift(mag * INV_GAIN_Q24, 24);
		vector_angle(rho, rot[2], lat, mag);
		s.src_col = COL_W'(pixel_of(lon + HALF_TURN, wspan, 20));
		s.src_row = ROW_W'(pixel_of(QUARTER_TURN - lat, hspan, 19));
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_ROW0:   mat_row[0] = val;
			REG_ROW1:   mat_row[1] = val;
			REG_ROW2:   mat_row[2] = val;
			REG_WIDTH:  width_reg = val[WIDTH_REG_W-1:0];
			REG_HEIGHT: height_reg = val[HEIGHT_REG_W-1:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	// pipeline must be empty before any register write
	task automatic drain;
		start <= 1'b0;
		while (board.pending.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
	endtask

	// start stays high after a transfer; idling or drain drops it
	task automatic send_pixel(input dest_t d);
		src_t s;
		if (!calm) begin
			while ($urandom_range(99) < 19) begin
				start <= 1'b0;
				@(posedge clk);
			end
		end
		start <= 1'b1;
		dest <= d;
		do @(posedge clk); while (busy);
		source_pixel(d, s);
		board.note_pixel(s);
	endtask

	function automatic logic [ROW_BITS-1:0] entry_row(int a, int b, int c);
		logic [ENTRY_W-1:0] ea, eb, ec;
		ea = ENTRY_W'(a);
		eb = ENTRY_W'(b);
		ec = ENTRY_W'(c);
		return {ec, eb, ea};
	endfunction

	task automatic random_rotation;
		int c, s;
		// mostly a plane rotation, sometimes arbitrary entries
		if ($urandom_range(3) == 0) begin
			for (int i = 0; i < 3; i++)
				write_reg(CFG_IDX_W'(i), CFG_DATA_W'({$urandom, $urandom}));
		end else begin
			c = $urandom_range(131072) - 65536;
			s = $urandom_range(131072) - 65536;
			case ($urandom_range(2))
				0: begin
					write_reg(REG_ROW0, entry_row(c, -s, 0));
					write_reg(REG_ROW1, entry_row(s, c, 0));
					write_reg(REG_ROW2, entry_row(0, 0, 65536));
				end
				1: begin
					write_reg(REG_ROW0, entry_row(c, 0, s));
					write_reg(REG_ROW1, entry_row(0, 65536, 0));
					write_reg(REG_ROW2, entry_row(-s, 0, c));
				end
				default: begin
					write_reg(REG_ROW0, entry_row(65536, 0, 0));
					write_reg(REG_ROW1, entry_row(0, c, -s));
					write_reg(REG_ROW2, entry_row(0, s, c));
				end
			endcase
		end
	endtask

	task automatic random_pixels(input int n);
		dest_t d;
		for (int k = 0; k < n; k++) begin
			calm = (k >= n / 2 && k < n / 2 + 40);
			if ($urandom_range(9) == 0) begin
				d.dest_col = COL_W'($urandom);
				d.dest_row = ROW_W'($urandom);
			end else begin
				d.dest_col = COL_W'($urandom_range(width_reg > 1 ? width_reg - 1 : 1));
				d.dest_row = ROW_W'($urandom_range(height_reg > 1 ? height_reg - 1 : 1));
			end
			send_pixel(d);
		end
		calm = 1'b0;
	endtask

	initial begin
		mat_row[0] = ROW0_RST;
		mat_row[1] = ROW1_RST;
		mat_row[2] = ROW2_RST;
		width_reg = WIDTH_RST;
		height_reg = HEIGHT_RST;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: corners, poles, equator, out-of-image pixels
		send_pixel('{dest_col: 0, dest_row: 0});
		send_pixel('{dest_col: 4095, dest_row: 2047});
		send_pixel('{dest_col: 2048, dest_row: 1024});
		send_pixel('{dest_col: 8191, dest_row: 4095});
		send_pixel('{dest_col: 1024, dest_row: 0});
		send_pixel('{dest_col: 3000, dest_row: 2047});
		drain();
		// zero matrix gives a zero rotated vector
		write_reg(REG_ROW0, '0);
		write_reg(REG_ROW1, '0);
		write_reg(REG_ROW2, '0);
		send_pixel('{dest_col: 100, dest_row: 200});
		send_pixel('{dest_col: 0, dest_row: 0});
		drain();
		// all-ones matrix, dimensions below minimum, unknown index ignored
		write_reg(REG_ROW0, '1);
		write_reg(REG_ROW1, '1);
		write_reg(REG_ROW2, '1);
		write_reg(REG_WIDTH, '0);
		write_reg(REG_HEIGHT, '0);
		write_reg(3'd7, '1);
		write_reg(3'd5, '0);
		send_pixel('{dest_col: 0, dest_row: 0});
		send_pixel('{dest_col: 8191, dest_row: 4095});
		send_pixel('{dest_col: 1, dest_row: 1});
		drain();
		// dimensions above maximum, half turn about the vertical
		write_reg(REG_WIDTH, '1);
		write_reg(REG_HEIGHT, '1);
		write_reg(REG_ROW0, entry_row(-65536, 0, 0));
		write_reg(REG_ROW1, entry_row(0, -65536, 0));
		write_reg(REG_ROW2, entry_row(0, 0, 65536));
		send_pixel('{dest_col: 0, dest_row: 4095});
		send_pixel('{dest_col: 8191, dest_row: 0});
		send_pixel('{dest_col: 4096, dest_row: 2048});
		drain();
		write_reg(REG_WIDTH, CFG_DATA_W'(8192));
		write_reg(REG_HEIGHT, CFG_DATA_W'(4096));
		write_reg(REG_ROW0, entry_row(0, 65536, 0));
		write_reg(REG_ROW1, entry_row(0, 0, 65536));
		write_reg(REG_ROW2, entry_row(65536, 0, 0));
		send_pixel('{dest_col: 8191, dest_row: 4095});
		send_pixel('{dest_col: 0, dest_row: 2047});
		send_pixel('{dest_col: 6000, dest_row: 100});
		drain();

		for (int ph = 0; ph < 10; ph++) begin
			case (ph % 4)
				0: write_reg(REG_WIDTH, CFG_DATA_W'(2));
				1: write_reg(REG_WIDTH, CFG_DATA_W'(8192));
				default: write_reg(REG_WIDTH, CFG_DATA_W'($urandom_range(8192, 2)));
			endcase
			case (ph % 3)
				0: write_reg(REG_HEIGHT, CFG_DATA_W'(4096));
				1: write_reg(REG_HEIGHT, CFG_DATA_W'(2));
				default: write_reg(REG_HEIGHT, CFG_DATA_W'($urandom_range(4096, 2)));
			endcase
			random_rotation();
			random_pixels(63);
			drain();
		end

		if (board.mismatches == 0 && board.pending.size() == 0)
			$display("tb_equirect_rotation_remap_address OK");
		else
			$display("tb_equirect_rotation_remap_address NOT OK");
		$finish;
	end
endmodule

`default_nettype wire

@@ filelist.f @@
hdl/erra_pkg.sv
hdl/equirect_rotation_remap_address.sv
test/tb_equirect_rotation_remap_address.sv
